// ===== hdl/dks_pkg.sv =====
// shared types, permutation tables and helper functions of the dual key schedule
package dks_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned HalfW  = 28;
  localparam int unsigned CdW    = 56;
  localparam int unsigned RkW    = 48;
  localparam int unsigned RoundW = 5;
  localparam logic [RoundW-1:0] MaxRounds = 5'd16;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef logic [HalfW-1:0] half_t;

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
    7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  function automatic logic [CdW-1:0] apply_pc1(input logic [KeyW-1:0] key);
    logic [CdW-1:0] r;
    r = '0;
    for (int i = 0; i < 56; i++) begin
      r[55-i] = key[6'(7'd64 - PC1_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [RkW-1:0] apply_pc2(input half_t c, input half_t d);
    logic [CdW-1:0] cd;
    logic [RkW-1:0] r;
    cd = {c, d};
    r  = '0;
    for (int i = 0; i < 48; i++) begin
      r[47-i] = cd[6'(6'd56 - PC2_TAB[i])];
    end
    return r;
  endfunction

  function automatic half_t rotl28(input half_t v, input logic two);
    return two ? {v[HalfW-3:0], v[HalfW-1:HalfW-2]} : {v[HalfW-2:0], v[HalfW-1]};
  endfunction

endpackage

// ===== hdl/des_key_schedule_dual_top.sv =====
// top level of the dual key schedule: one shared rotate and pc-2 unit stepped per round
//
//  channel | dir | handshake                  | payload
//  in      | in  | in_valid_i / in_stall_o    | key_a_i, key_b_i
//  out     | out | out_valid_o / out_stall_i  | round_key_a_o, round_key_b_o, round_index_o, last_o
//  cfg     | in  | cfg_we_i                   | cfg_data_i (round count)
//
// an item is taken and loaded through pc-1, then one round pair per cycle goes through the shared
// rotate and pc-2 unit while the output is not stalled; n rounds give n results
// the input stays stalled until the last round is loaded into the output register
// a stall on the output holds the round unit; reset clears control, round count goes to 16
module des_key_schedule_dual_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] key_a_i,
  input  logic [63:0] key_b_i,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] round_key_a_o,
  output logic [47:0] round_key_b_o,
  output logic [4:0]  round_index_o,
  output logic        last_o
);

  dks_pkg::state_e state_q, state_d;

  dks_pkg::half_t ca_q, ca_d, da_q, da_d, cb_q, cb_d, db_q, db_d;
  logic [4:0]  rc_q, rc_d;
  logic [4:0]  n_q, n_d;
  logic [4:0]  round_q, round_d;
  logic        out_valid_q, out_valid_d;
  logic [47:0] rka_q, rka_d, rkb_q, rkb_d;
  logic [4:0]  idx_q, idx_d;
  logic        last_q, last_d;

  logic        in_acc;
  logic        advance;
  logic        busy;
  logic [4:0]  next_round;
  logic        shift_two;
  logic [55:0] pc1_a, pc1_b;
  dks_pkg::half_t ca_rot, da_rot, cb_rot, db_rot;

  // outputs of the sequencer
  always_comb begin
    busy    = 1'b0;
    advance = 1'b0;
    unique case (state_q)
      dks_pkg::ST_IDLE: busy = 1'b0;
      dks_pkg::ST_RUN: begin
        busy    = 1'b1;
        advance = !out_valid_q || !out_stall_i;
      end
      default: busy = 1'b1;
    endcase
  end

  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dks_pkg::ST_IDLE: if (in_acc) state_d = dks_pkg::ST_RUN;
      dks_pkg::ST_RUN:  if (advance && (next_round == n_q)) state_d = dks_pkg::ST_IDLE;
      default:          state_d = dks_pkg::ST_IDLE;
    endcase
  end

  // shared round unit
  assign next_round = round_q + 5'd1;
  assign shift_two  = !((next_round == 5'd1) || (next_round == 5'd2) ||
                        (next_round == 5'd9) || (next_round == dks_pkg::MaxRounds));
  assign ca_rot = dks_pkg::rotl28(ca_q, shift_two);
  assign da_rot = dks_pkg::rotl28(da_q, shift_two);
  assign cb_rot = dks_pkg::rotl28(cb_q, shift_two);
  assign db_rot = dks_pkg::rotl28(db_q, shift_two);

  assign pc1_a = dks_pkg::apply_pc1(key_a_i);
  assign pc1_b = dks_pkg::apply_pc1(key_b_i);

  always_comb begin
    ca_d        = ca_q;
    da_d        = da_q;
    cb_d        = cb_q;
    db_d        = db_q;
    rc_d        = cfg_we_i ? cfg_data_i : rc_q;
    n_d         = n_q;
    round_d     = round_q;
    out_valid_d = out_valid_q && out_stall_i;
    rka_d       = rka_q;
    rkb_d       = rkb_q;
    idx_d       = idx_q;
    last_d      = last_q;
    if (in_acc) begin
      ca_d    = pc1_a[55:28];
      da_d    = pc1_a[27:0];
      cb_d    = pc1_b[55:28];
      db_d    = pc1_b[27:0];
      round_d = '0;
      if (rc_q == 5'd0) begin
        n_d = 5'd1;
      end else if (rc_q > dks_pkg::MaxRounds) begin
        n_d = dks_pkg::MaxRounds;
      end else begin
        n_d = rc_q;
      end
    end
    if (advance) begin
      ca_d        = ca_rot;
      da_d        = da_rot;
      cb_d        = cb_rot;
      db_d        = db_rot;
      round_d     = next_round;
      out_valid_d = 1'b1;
      rka_d       = dks_pkg::apply_pc2(ca_rot, da_rot);
      rkb_d       = dks_pkg::apply_pc2(cb_rot, db_rot);
      idx_d       = next_round;
      last_d      = (next_round == n_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dks_pkg::ST_IDLE;
      rc_q        <= dks_pkg::MaxRounds;
      n_q         <= 5'd1;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rc_q        <= rc_d;
      n_q         <= n_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q   <= ca_d;
    da_q   <= da_d;
    cb_q   <= cb_d;
    db_q   <= db_d;
    rka_q  <= rka_d;
    rkb_q  <= rkb_d;
    idx_q  <= idx_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign round_key_a_o = rka_q;
  assign round_key_b_o = rkb_q;
  assign round_index_o = idx_q;
  assign last_o        = last_q;

endmodule

// ===== hdl/dks_checker.sv =====
// port-level checker of the dual key schedule and its bind to the top level
module dks_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [47:0] round_key_a_o,
  input logic [4:0]  round_index_o,
  input logic        last_o
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // busy right after an item is taken
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after an item was taken");

  // rounds follow each other without gaps
  a_round_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_o |=> out_valid_o && (round_index_o == $past(round_index_o) + 5'd1))
    else $error("next round missing or out of order");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (round_index_o != 5'd0) && (round_index_o <= 5'd16))
    else $error("round index out of range");

  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(round_key_a_o) &&
      $stable(round_index_o))
    else $error("stalled item changed");

endmodule

bind des_key_schedule_dual_top dks_checker u_dks_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .round_key_a_o (round_key_a_o),
  .round_index_o (round_index_o),
  .last_o        (last_o)
);
